/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define DPIC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same, on the standard clock and reset names of this project.
`define DPIC_ASSERT_STD(name, prop, msg) \
  `DPIC_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

/* rtl/dpic_pkg.sv */
// ----------------------------------------------------------------------------
// dpic_pkg
// Shared types and constants of the depth player index colorizer.
// ----------------------------------------------------------------------------
package dpic_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned DepthW   = SampleW - IdxW;
  localparam int unsigned RgbW     = 24;
  localparam int unsigned PlayersW = 6;
  localparam int unsigned CountW   = 3;
  localparam int unsigned OutW     = RgbW + PlayersW + CountW;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  localparam int unsigned AddrW = 5;

  // register indexes (paddr[4:2])
  localparam logic [2:0] RegBinaryMode  = 3'd0;
  localparam logic [2:0] RegInvertBin   = 3'd1;
  localparam logic [2:0] RegColorize    = 3'd2;
  localparam logic [2:0] RegRemoveBg    = 3'd3;
  localparam logic [2:0] RegDepthOnly   = 3'd4;

  typedef struct packed {
    logic binary_mode;
    logic invert_binary;
    logic colorize_players;
    logic remove_background;
    logic depth_only_format;
  } cfg_t;

endpackage

/* rtl/dpic_color.sv */
// ----------------------------------------------------------------------------
// dpic_color
// Per-pixel datapath: intensity from depth, colour selection, player flags.
// ----------------------------------------------------------------------------
module dpic_color (
  input  dpic_pkg::cfg_t                      cfg_i,
  input  logic [dpic_pkg::SampleW-1:0]        sample_i,
  input  logic [dpic_pkg::PlayersW-1:0]       seen_i,
  output logic [dpic_pkg::RgbW-1:0]           rgb_o,
  output logic [dpic_pkg::PlayersW-1:0]       seen_o,
  output logic [dpic_pkg::CountW-1:0]         count_o
);
  import dpic_pkg::*;

  logic [SampleW-1:0] word;
  logic [DepthW-1:0]  depth;
  logic [IdxW-1:0]    idx;
  logic               in_range;
  logic               bg;
  logic [16:0]        x17;     // depth * 17, max 69615
  logic [24:0]        xr;      // x17 * 240, reciprocal of 273 at 2^-16
  logic [7:0]         q_est;
  logic [16:0]        rem;
  logic [7:0]         quot;
  logic [7:0]         inten;
  logic [7:0]         half;
  logic [7:0]         quart;
  logic [7:0]         r_ch, g_ch, b_ch;

  function automatic logic [RgbW-1:0] grey(input logic [7:0] v);
    grey = {v, v, v};
  endfunction

  always_comb begin
    word = cfg_i.depth_only_format ? {sample_i[SampleW-IdxW-1:0], {IdxW{1'b0}}} : sample_i;
    depth = word[SampleW-1:IdxW];
    idx   = word[IdxW-1:0];
    in_range = (depth != '0) && (depth[DepthW-1] == 1'b0);
    bg = (idx == 3'd0) || (idx == 3'd7);

    // floor(depth*17/273): estimate is exact or one low, one correction step
    x17   = {depth[DepthW-2:0], 4'b0} + {5'b0, depth[DepthW-2:0]};
    xr    = {x17, 8'b0} - {4'b0, x17, 4'b0};
    q_est = xr[23:16];
    rem   = x17 - (17'(q_est) * 17'd273);
    quot  = (rem >= 17'd273) ? q_est + 8'd1 : q_est;
    inten = in_range ? 8'd255 - quot : 8'd0;
    half  = {1'b0, inten[7:1]};
    quart = {2'b0, inten[7:2]};

    r_ch = inten;
    g_ch = 8'd0;
    b_ch = 8'd0;
    case (idx)
      3'd2: g_ch = inten;
      3'd3: b_ch = inten;
      3'd4: g_ch = half;
      3'd5: b_ch = half;
      3'd6: begin
        g_ch = half;
        b_ch = half;
      end
      default: ;
    endcase

    if (cfg_i.binary_mode) begin
      rgb_o = (bg == cfg_i.invert_binary) ? grey(8'hFF) : '0;
    end else if (cfg_i.colorize_players) begin
      if (idx == 3'd0) begin
        rgb_o = cfg_i.remove_background ? '0 : grey(quart);
      end else if (idx == 3'd7) begin
        rgb_o = cfg_i.remove_background ? '0 : grey(8'd255 - half);
      end else begin
        rgb_o = {r_ch, g_ch, b_ch};
      end
    end else begin
      rgb_o = (bg && cfg_i.remove_background) ? '0 : grey(inten);
    end

    seen_o = seen_i;
    if (!bg) begin
      seen_o[idx - 3'd1] = 1'b1;
    end
    count_o = CountW'(seen_o[0]) + CountW'(seen_o[1]) + CountW'(seen_o[2])
            + CountW'(seen_o[3]) + CountW'(seen_o[4]) + CountW'(seen_o[5]);
  end

endmodule

/* rtl/depth_player_index_colorizer.sv */
// ----------------------------------------------------------------------------
// depth_player_index_colorizer
// Colours a stream of depth samples by intensity and player index.
// ----------------------------------------------------------------------------
//  port group   dir  width  contents
//  s_axis       in   16     sample
//  m_axis       out  40     rgb, active_players, player_count
//  apb          in   5/32   five 1-bit mode registers at 0x00..0x10
//
//  One word per cycle sustained while the output is not stalled; an
//  accepted word passes through the input register, then the result
//  register, before it is presented on the output.
//  The colour datapath between the two registers sets the clock rate.
//  Reset clears the mode registers, player flags and both valid bits.
//  A stalled output holds its word; input keeps flowing while the
//  input register can drain into the result register.
// ----------------------------------------------------------------------------
module depth_player_index_colorizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [dpic_pkg::SampleW-1:0]       s_axis_tdata,   // [15:0] sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [23:0] rgb, [29:24] active_players, [32:30] player_count, rest zero
  output logic [dpic_pkg::OutBytesW-1:0]     m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dpic_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import dpic_pkg::*;

  cfg_t                 cfg_q;
  logic                 s1_valid_q, s1_valid_d;
  logic [SampleW-1:0]   s1_sample_q;
  logic                 m_valid_q, m_valid_d;
  logic [OutW-1:0]      m_data_q;
  logic [PlayersW-1:0]  seen_q;
  logic [RgbW-1:0]      rgb;
  logic [PlayersW-1:0]  seen_new;
  logic [CountW-1:0]    count;
  logic                 out_adv;
  logic                 in_acc;
  logic                 fire;
  logic                 cfg_wr;
  logic [2:0]           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegBinaryMode: cfg_q.binary_mode       <= pwdata[0];
        RegInvertBin:  cfg_q.invert_binary     <= pwdata[0];
        RegColorize:   cfg_q.colorize_players  <= pwdata[0];
        RegRemoveBg:   cfg_q.remove_background <= pwdata[0];
        RegDepthOnly:  cfg_q.depth_only_format <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegBinaryMode: prdata[0] = cfg_q.binary_mode;
      RegInvertBin:  prdata[0] = cfg_q.invert_binary;
      RegColorize:   prdata[0] = cfg_q.colorize_players;
      RegRemoveBg:   prdata[0] = cfg_q.remove_background;
      RegDepthOnly:  prdata[0] = cfg_q.depth_only_format;
      default: ;
    endcase
  end

  // two-register pipeline; stage 1 moves on whenever the result slot frees
  assign out_adv       = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fire          = s1_valid_q && out_adv;
  assign s1_valid_d    = in_acc || (s1_valid_q && !out_adv);
  assign m_valid_d     = out_adv ? s1_valid_q : m_valid_q;

  dpic_color u_color (
    .cfg_i    (cfg_q),
    .sample_i (s1_sample_q),
    .seen_i   (seen_q),
    .rgb_o    (rgb),
    .seen_o   (seen_new),
    .count_o  (count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      seen_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
      if (fire) begin
        seen_q <= seen_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= s_axis_tdata;
    end
    if (fire) begin
      m_data_q <= {count, seen_new, rgb};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutBytesW - OutW){1'b0}}, m_data_q};

endmodule

/* rtl/dpic_checker.sv */
// ----------------------------------------------------------------------------
// dpic_checker
// Port-level checks of the colorizer output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpic_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dpic_pkg::OutBytesW-1:0]  m_axis_tdata
);
  import dpic_pkg::*;

  logic [PlayersW-1:0] prev_active_q;
  logic [PlayersW-1:0] active;
  logic [CountW-1:0]   pcount;
  logic                out_acc;

  assign active  = m_axis_tdata[RgbW +: PlayersW];
  assign pcount  = m_axis_tdata[RgbW + PlayersW +: CountW];
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // flags of the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_active_q <= '0;
    end else if (out_acc) begin
      prev_active_q <= active;
    end
  end

  `DPIC_ASSERT_STD(a_count_matches, m_axis_tvalid |-> (32'(pcount) == $countones(active)), "player_count disagrees with active_players")
  `DPIC_ASSERT_STD(a_flags_sticky, out_acc |-> ((active & prev_active_q) == prev_active_q), "player flag cleared after being set")
  `DPIC_ASSERT_STD(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled output word changed")

endmodule

bind depth_player_index_colorizer dpic_checker u_dpic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
